[hdl/piecewise_linear_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator assertion macros
// Shorthand for clocked assertions; clk_i and rst_ni are taken from the scope.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define PLINT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLINT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/plint_pkg.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, codes and the command and status bundles.
// ----------------------------------------------------------------------------
package plint_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] RS_IN_RANGE   = 2'd0;
  localparam logic [STATUS_W-1:0] RS_BELOW      = 2'd1;
  localparam logic [STATUS_W-1:0] RS_ABOVE      = 2'd2;
  localparam logic [STATUS_W-1:0] RS_ZERO_WIDTH = 2'd3;

  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_SEG,
    RD_SEG_NEXT
  } rdsel_e;

  typedef struct packed {
    logic   wr;
    logic   start;
    logic   rd_en;
    rdsel_e rd_sel;
    logic   cap_first;
    logic   cap_last;
    logic   bis_step;
    logic   seg_eval;
    logic   cap_p0;
    logic   diff;
    logic   mul;
    logic   div_start;
    logic   fin;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic bis_done;
    logic skip;
    logic div_busy;
  } sts_t;

endpackage

[hdl/plint_div.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator divider
// Restoring 64/32 divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module plint_div import plint_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*DATA_W-1:0]   dividend_i,
  input  logic [DATA_W-1:0]     divisor_i,
  output logic                  busy_o,
  output logic                  ovf_o,
  output logic [DATA_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quot_q;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diffv;
  logic              fits;
  logic              ovf_d;

  assign trial = {rem_q, quot_q[DATA_W-1]};
  assign diffv = trial - {1'b0, dvs_q};
  assign fits  = ~diffv[DATA_W];
  assign ovf_d = dividend_i[2*DATA_W-1:DATA_W] >= divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= ~ovf_d;
      ovf_q  <= ovf_d;
      cnt_q  <= '1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[2*DATA_W-1:DATA_W];
      quot_q <= dividend_i[DATA_W-1:0];
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diffv[DATA_W-1:0] : trial[DATA_W-1:0];
      quot_q <= {quot_q[DATA_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign ovf_o  = ovf_q;
  assign quot_o = quot_q;

endmodule

[hdl/plint_dp.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator datapath
// Breakpoint memory, bisection bounds, interpolation arithmetic and result.
// ----------------------------------------------------------------------------
module plint_dp import plint_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [COUNT_W-1:0]         cfg_wdata_i,
  input  logic [SLOT_W-1:0]          point_index_i,
  input  logic signed [DATA_W-1:0]   x_value_i,
  input  logic signed [DATA_W-1:0]   y_value_i,
  input  logic                       last_query_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  output logic signed [DATA_W-1:0]   y_out_o,
  output logic [STATUS_W-1:0]        range_status_o,
  output logic [SLOT_W-1:0]          segment_index_o,
  output logic                       last_result_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int unsigned LW = AW + 2;
  localparam int unsigned EW = DATA_W + 1;
  localparam int unsigned QW = DATA_W + 2;

  localparam logic signed [LW-1:0] ONE_S  = LW'(1);
  localparam logic signed [LW-1:0] TWO_S  = LW'(2);
  localparam logic [DATA_W-1:0]    HALF   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [QW-1:0] SAT_HI = {3'b000, {(DATA_W-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = {3'b111, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] mag(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] a;
    a = v[EW-1] ? -v : v;
    return a[DATA_W-1:0];
  endfunction

  logic [COUNT_W-1:0]       count_q;
  logic [2*DATA_W-1:0]      mem_q [TABLE_DEPTH];
  logic [2*DATA_W-1:0]      rdata_q;
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;
  logic [SLOT_W+AW-1:0]     slot_ext;
  logic                     wr_ok;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [CW-1:0]            count_ext;
  logic [CW-1:0]            n_clamp;
  logic [NW-1:0]            n_q;
  logic [NW-1:0]            nm1;
  logic signed [LW-1:0]     n_s;
  logic signed [LW-1:0]     nm1_s;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] xfirst_q;
  logic signed [DATA_W-1:0] xlast_q;
  logic signed [DATA_W-1:0] x0_q;
  logic signed [DATA_W-1:0] y0_q;
  logic                     last_q;
  logic                     asc_q;
  logic signed [LW-1:0]     lo_q;
  logic signed [LW-1:0]     hi_q;
  logic signed [LW-1:0]     seg_q;
  logic signed [LW-1:0]     seg_d;
  logic [LW:0]              span;
  logic [LW:0]              sum;
  logic [AW-1:0]            mid;
  logic [AW-1:0]            mid_q;
  logic [AW-1:0]            seg_next;
  logic                     ge;
  logic                     below;
  logic                     above;
  logic [SLOT_W+AW-1:0]     seg_ext;
  logic signed [EW-1:0]     dx;
  logic signed [EW-1:0]     dy;
  logic signed [EW-1:0]     dxq;
  logic [DATA_W-1:0]        mdx_q;
  logic [DATA_W-1:0]        mdy_q;
  logic [DATA_W-1:0]        mdxq_q;
  logic                     neg_q;
  logic [2*DATA_W-1:0]      prod_d;
  logic [2*DATA_W-1:0]      prod_q;
  logic                     div_busy;
  logic                     div_ovf;
  logic [DATA_W-1:0]        quot;
  logic signed [QW-1:0]     qm_ext;
  logic signed [QW-1:0]     q_s;
  logic signed [QW-1:0]     y_sum;
  logic signed [DATA_W-1:0] y_sat;
  logic signed [DATA_W-1:0] res_y_q;
  logic [STATUS_W-1:0]      res_status_q;
  logic [SLOT_W-1:0]        res_seg_q;
  logic signed [DATA_W-1:0] y_out_q;
  logic [STATUS_W-1:0]      status_out_q;
  logic [SLOT_W-1:0]        seg_out_q;
  logic                     last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign slot_ext = {{AW{1'b0}}, point_index_i};
  assign wr_ok    = slot_ext < (SLOT_W+AW)'(TABLE_DEPTH);
  assign wr_addr  = slot_ext[AW-1:0];

  assign rd_x = rdata_q[2*DATA_W-1:DATA_W];
  assign rd_y = rdata_q[DATA_W-1:0];

  assign count_ext = CW'(count_q);
  always_comb begin
    if (count_ext < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (count_ext > CW'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = count_ext;
    end
  end

  assign nm1      = n_q - NW'(1);
  assign n_s      = $signed({1'b0, n_q});
  assign nm1_s    = n_s - ONE_S;
  assign span     = {hi_q[LW-1], hi_q} - {lo_q[LW-1], lo_q};
  assign sum      = {hi_q[LW-1], hi_q} + {lo_q[LW-1], lo_q};
  assign mid      = sum[AW:1];
  assign seg_next = seg_q[AW-1:0] + AW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST:    rd_addr = '0;
      RD_LAST:     rd_addr = nm1[AW-1:0];
      RD_MID:      rd_addr = mid;
      RD_SEG:      rd_addr = seg_q[AW-1:0];
      RD_SEG_NEXT: rd_addr = seg_next;
      default:     rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[wr_addr] <= {x_value_i, y_value_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign ge = x_q >= rd_x;

  always_comb begin
    if (x_q == xfirst_q) begin
      seg_d = '0;
    end else if (x_q == xlast_q) begin
      seg_d = n_s - TWO_S;
    end else begin
      seg_d = lo_q;
    end
  end

  assign below   = seg_d[LW-1];
  assign above   = ~below && (seg_d >= nm1_s);
  assign seg_ext = {{SLOT_W{1'b0}}, seg_d[AW-1:0]};

  assign dx  = {rd_x[DATA_W-1], rd_x} - {x0_q[DATA_W-1], x0_q};
  assign dy  = {rd_y[DATA_W-1], rd_y} - {y0_q[DATA_W-1], y0_q};
  assign dxq = {x_q[DATA_W-1], x_q} - {x0_q[DATA_W-1], x0_q};

  assign prod_d = mdy_q * mdxq_q;

  plint_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (mdx_q),
    .busy_o     (div_busy),
    .ovf_o      (div_ovf),
    .quot_o     (quot)
  );

  assign qm_ext = $signed({2'b00, quot});

  always_comb begin
    if (div_ovf) begin
      q_s = neg_q ? SAT_LO : SAT_HI;
    end else if (neg_q) begin
      q_s = (quot > HALF) ? SAT_LO : -qm_ext;
    end else begin
      q_s = quot[DATA_W-1] ? SAT_HI : qm_ext;
    end
    y_sum = {{2{y0_q[DATA_W-1]}}, y0_q} + q_s;
    if (y_sum > SAT_HI) begin
      y_sat = SAT_HI[DATA_W-1:0];
    end else if (y_sum < SAT_LO) begin
      y_sat = SAT_LO[DATA_W-1:0];
    end else begin
      y_sat = y_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= x_value_i;
      last_q <= last_query_i;
      n_q    <= n_clamp[NW-1:0];
      lo_q   <= '1;
      hi_q   <= $signed({1'b0, n_clamp[NW-1:0]});
    end
    if (cmd_i.cap_first) begin
      xfirst_q <= rd_x;
    end
    if (cmd_i.cap_last) begin
      xlast_q <= rd_x;
      asc_q   <= rd_x >= xfirst_q;
    end
    if (cmd_i.rd_en) begin
      mid_q <= mid;
    end
    if (cmd_i.bis_step) begin
      if (ge == asc_q) begin
        lo_q <= $signed({2'b00, mid_q});
      end else begin
        hi_q <= $signed({2'b00, mid_q});
      end
    end
    if (cmd_i.seg_eval) begin
      seg_q   <= seg_d;
      res_y_q <= '0;
      if (below) begin
        res_status_q <= RS_BELOW;
        res_seg_q    <= '0;
      end else if (above) begin
        res_status_q <= RS_ABOVE;
        res_seg_q    <= '0;
      end else begin
        res_status_q <= RS_IN_RANGE;
        res_seg_q    <= seg_ext[SLOT_W-1:0];
      end
    end
    if (cmd_i.cap_p0) begin
      x0_q <= rd_x;
      y0_q <= rd_y;
    end
    if (cmd_i.diff) begin
      mdx_q  <= mag(dx);
      mdy_q  <= mag(dy);
      mdxq_q <= mag(dxq);
      neg_q  <= dx[EW-1] ^ dy[EW-1] ^ dxq[EW-1];
      if (dx == '0) begin
        res_status_q <= RS_ZERO_WIDTH;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fin) begin
      res_y_q <= y_sat;
    end
    if (cmd_i.load_out) begin
      y_out_q      <= res_y_q;
      status_out_q <= res_status_q;
      seg_out_q    <= res_seg_q;
      last_out_q   <= last_q;
    end
  end

  assign sts_o.bis_done = span <= (LW+1)'(1);
  assign sts_o.skip     = res_status_q != RS_IN_RANGE;
  assign sts_o.div_busy = div_busy;

  assign y_out_o         = y_out_q;
  assign range_status_o  = status_out_q;
  assign segment_index_o = seg_out_q;
  assign last_result_o   = last_out_q;

endmodule

[hdl/plint_ctrl.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator controller
// Sequences table writes, bisection, interpolation and result hand-off.
// ----------------------------------------------------------------------------
module plint_ctrl import plint_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic req_type_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_CAP_LAST,
    S_BIS_ISSUE,
    S_BIS_CMP,
    S_SEG,
    S_RD_SEG,
    S_RD_NEXT,
    S_DIFF,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_QUERY) begin
            cmd.start = 1'b1;
            state_d   = S_RD_FIRST;
          end else if (req_type_i == REQ_WRITE) begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST;
        state_d    = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.cap_first = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_LAST;
        state_d       = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd.cap_last = 1'b1;
        state_d      = S_BIS_ISSUE;
      end
      S_BIS_ISSUE: begin
        if (sts_i.bis_done) begin
          state_d = S_SEG;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_d    = S_BIS_CMP;
        end
      end
      S_BIS_CMP: begin
        cmd.bis_step = 1'b1;
        state_d      = S_BIS_ISSUE;
      end
      S_SEG: begin
        cmd.seg_eval = 1'b1;
        state_d      = S_RD_SEG;
      end
      S_RD_SEG: begin
        if (sts_i.skip) begin
          state_d = S_OUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SEG;
          state_d    = S_RD_NEXT;
        end
      end
      S_RD_NEXT: begin
        cmd.cap_p0 = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SEG_NEXT;
        state_d    = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        if (sts_i.skip) begin
          state_d = S_OUT;
        end else begin
          cmd.mul = 1'b1;
          state_d = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[hdl/piecewise_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with bisection lookup and Q16.16 linear interpolation.
//
//   channel   handshake                  payload
//   -------   ------------------------   ----------------------------------
//   input     in_valid_i / in_ready_o    req_type, point_index, x, y, last
//   output    out_valid_o / out_ready_i  y_out, range_status, segment, last
//   config    cfg_we_i                   cfg_wdata_i (point_count)
//
// A write transaction is taken in the idle state, which it does not leave. A query
// is taken only there and runs a bisection over the n points in use, reading one
// entry at a time through the single read port, and then the 32-step restoring
// divider; in_ready_o stays low from accept until the result of the query is loaded.
// Out-of-range and zero-width queries skip the multiply and divide.
// Reset clears the controller and sets point_count to 2; table contents are
// kept and must be written before use. A stalled result holds in the output
// register; writes and a further query are still taken, but that result waits.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import plint_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [COUNT_W-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic [SLOT_W-1:0]        point_index_i,
  input  logic signed [DATA_W-1:0] x_value_i,
  input  logic signed [DATA_W-1:0] y_value_i,
  input  logic                     last_query_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] y_out_o,
  output logic [STATUS_W-1:0]      range_status_o,
  output logic [SLOT_W-1:0]        segment_index_o,
  output logic                     last_result_o
);

  cmd_t cmd;
  sts_t sts;

  plint_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plint_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .point_index_i   (point_index_i),
    .x_value_i       (x_value_i),
    .y_value_i       (y_value_i),
    .last_query_i    (last_query_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .y_out_o         (y_out_o),
    .range_status_o  (range_status_o),
    .segment_index_o (segment_index_o),
    .last_result_o   (last_result_o)
  );

endmodule

[hdl/plint_chk.sv]
// ----------------------------------------------------------------------------
// Piecewise linear interpolator checker
// Port-level assertions on results and handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_defines.svh"

module plint_chk import plint_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     req_type_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] y_out_o,
  input logic [STATUS_W-1:0]      range_status_o,
  input logic [SLOT_W-1:0]        segment_index_o,
  input logic                     last_result_o
);

  // hold a stalled result
  `PLINT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(y_out_o) && $stable(range_status_o) && $stable(segment_index_o) && $stable(last_result_o), "stalled result changed")

  `PLINT_ASSERT_NOW(a_range_zero, out_valid_o && (range_status_o == RS_BELOW || range_status_o == RS_ABOVE), y_out_o == '0 && segment_index_o == '0, "out-of-range result not zero")

  `PLINT_ASSERT_NOW(a_width_zero, out_valid_o && range_status_o == RS_ZERO_WIDTH, y_out_o == '0, "zero-width result not zero")

  `PLINT_ASSERT_NEXT(a_query_busy, in_valid_i && in_ready_o && req_type_i == REQ_QUERY, !in_ready_o, "ready right after a query transaction")

endmodule

bind piecewise_linear_interpolator plint_chk u_chk (.*);
